FILE: rtl/spfgh_pkg.sv
// ----------------------------------------------------------------------------
// spfgh_pkg: shared definitions for the signed prefix flip gap heuristic
// mode codes, default stack depth and controller/datapath interface structs
// ----------------------------------------------------------------------------
package spfgh_pkg;

    // default number of stack slots
    localparam int STACK_SIZE_DEF = 16;

    // field widths fixed by the item format
    localparam int MODE_W  = 2;
    localparam int POS_W   = 4;
    localparam int PC_W    = 6;
    localparam int FLIP_W  = 5;
    localparam int HEUR_W  = 5;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_LOAD_GOAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_CUR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLIP      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EVAL      = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;       // beat taken this cycle
        logic rd_en;        // capture stack reads at up and lo
        logic wr_up;        // flip: write negated lo entry at up
        logic wr_lo;        // flip: write negated up entry at lo
        logic step;         // flip: move up and lo toward each other
        logic issue;        // eval: one stack entry enters the pipeline
        logic finish_flip;  // flip result
        logic finish_eval;  // eval result
    } spfgh_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic flip_ok;      // flip count in range
        logic up_lt_lo;
        logic up_eq_lo;
        logic idx_last;     // eval index at bottom slot
    } spfgh_status_t;

endpackage

FILE: rtl/spfgh_ctrl.sv
// ----------------------------------------------------------------------------
// spfgh_ctrl: sequencing state machine
// accepts commands, steps flips pair by pair and walks the stack for eval
// ----------------------------------------------------------------------------
module spfgh_ctrl
    import spfgh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MODE_W-1:0] mode,
    input  spfgh_status_t     status,
    output spfgh_cmd_t        cmd,
    output logic              busy
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_FLIP_RD = 4'd1;
    localparam logic [3:0] ST_FLIP_WU = 4'd2;
    localparam logic [3:0] ST_FLIP_WL = 4'd3;
    localparam logic [3:0] ST_FLIP_WM = 4'd4;
    localparam logic [3:0] ST_EVAL    = 4'd5;
    localparam logic [3:0] ST_DRAIN1  = 4'd6;
    localparam logic [3:0] ST_DRAIN2  = 4'd7;
    localparam logic [3:0] ST_EDONE   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = start;
                if (start)
                begin
                    if (mode == MODE_FLIP && status.flip_ok)
                    begin
                        state_next = ST_FLIP_RD;
                    end
                    else if (mode == MODE_EVAL)
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_FLIP_RD:
            begin
                cmd.rd_en = 1'b1;
                if (status.up_lt_lo)
                begin
                    state_next = ST_FLIP_WU;
                end
                else if (status.up_eq_lo)
                begin
                    state_next = ST_FLIP_WM;
                end
                else
                begin
                    cmd.finish_flip = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_FLIP_WU:
            begin
                cmd.wr_up  = 1'b1;
                state_next = ST_FLIP_WL;
            end
            ST_FLIP_WL:
            begin
                cmd.wr_lo  = 1'b1;
                cmd.step   = 1'b1;
                state_next = ST_FLIP_RD;
            end
            ST_FLIP_WM:
            begin
                // middle entry of an odd flip only changes sign
                cmd.wr_lo       = 1'b1;
                cmd.finish_flip = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_EVAL:
            begin
                cmd.rd_en = 1'b1;
                cmd.issue = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1:
            begin
                state_next = ST_DRAIN2;
            end
            ST_DRAIN2:
            begin
                state_next = ST_EDONE;
            end
            ST_EDONE:
            begin
                cmd.finish_eval = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: rtl/spfgh_dp.sv
// ----------------------------------------------------------------------------
// spfgh_dp: stack and goal memories, flip pointers and gap pipeline
// evaluates one stack entry per cycle through a two stage read pipeline
// ----------------------------------------------------------------------------
module spfgh_dp
    import spfgh_pkg::*;
#(
    parameter int STACK_SIZE = STACK_SIZE_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [MODE_W-1:0]       mode,
    input  logic [POS_W-1:0]        position,
    input  logic signed [PC_W-1:0]  pancake,
    input  logic [FLIP_W-1:0]       flip_count,
    input  spfgh_cmd_t              cmd,
    output spfgh_status_t           status,
    output logic                    done,
    output logic [HEUR_W-1:0]       heuristic,
    output logic                    error
);

    localparam int IDX_W = $clog2(STACK_SIZE);
    localparam int CNT_W = $clog2(2 * STACK_SIZE) + 1;

    logic signed [PC_W-1:0] stack_mem [STACK_SIZE];
    logic signed [PC_W-1:0] goal_mem  [STACK_SIZE];

    logic [IDX_W-1:0]       up_reg;
    logic [IDX_W-1:0]       lo_reg;
    logic signed [PC_W-1:0] rd_a_reg;
    logic signed [PC_W-1:0] rd_b_reg;
    logic signed [PC_W-1:0] goal_rd_reg;
    logic                   s1_valid_reg, s1_first_reg, s1_last_reg;
    logic                   s2_valid_reg, s2_first_reg, s2_last_reg;
    logic                   s2_neg_reg;
    logic signed [PC_W-1:0] prev_loc_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   done_reg;
    logic                   err_reg;
    logic [HEUR_W-1:0]      heur_reg;

    logic [PC_W-1:0]        mag_in;
    logic                   load_bad;
    logic                   slot_ok;
    logic                   ld_goal;
    logic                   ld_cur;
    logic [PC_W-1:0]        goal_pos;
    logic signed [PC_W-1:0] goal_val;
    logic [PC_W-1:0]        rd_a_mag;
    logic [IDX_W-1:0]       goal_addr;
    logic signed [PC_W-1:0] loc;
    logic [PC_W-1:0]        mag_a;
    logic [PC_W-1:0]        mag_b;
    logic [PC_W-1:0]        mag_diff;
    logic                   opp_sign;
    logic [1:0]             pair_inc;
    logic                   bot_inc;
    logic [7:0]             cnt_ext;
    logic [HEUR_W-1:0]      heur_sat;
    logic                   immediate;

    // load decode
    assign mag_in   = pancake[PC_W-1] ? (~pancake + 6'd1) : pancake;
    assign load_bad = (pancake == 6'sd0) || ({1'b0, mag_in} > 7'(STACK_SIZE));
    assign slot_ok  = ({2'b00, position} < 6'(STACK_SIZE));
    assign ld_goal  = cmd.accept && (mode == MODE_LOAD_GOAL) && !load_bad && slot_ok;
    assign ld_cur   = cmd.accept && (mode == MODE_LOAD_CUR) && !load_bad && slot_ok;
    assign goal_pos = {2'b00, position} + 6'd1;
    assign goal_val = pancake[PC_W-1] ? $signed(~goal_pos + 6'd1) : $signed(goal_pos);

    // status toward the controller
    assign status.flip_ok  = (flip_count >= 5'd2) && ({1'b0, flip_count} <= 6'(STACK_SIZE));
    assign status.up_lt_lo = (up_reg < lo_reg);
    assign status.up_eq_lo = (up_reg == lo_reg);
    assign status.idx_last = (up_reg == IDX_W'(STACK_SIZE - 1));

    // goal lookup address from the captured stack entry
    assign rd_a_mag  = rd_a_reg[PC_W-1] ? (~rd_a_reg + 6'd1) : rd_a_reg;
    assign goal_addr = IDX_W'(rd_a_mag - 6'd1);

    // stack memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (ld_cur)
        begin
            stack_mem[IDX_W'(position)] <= pancake;
        end
        else if (cmd.wr_up)
        begin
            stack_mem[up_reg] <= -rd_b_reg;
        end
        else if (cmd.wr_lo)
        begin
            stack_mem[lo_reg] <= -rd_a_reg;
        end
        if (cmd.rd_en)
        begin
            rd_a_reg <= stack_mem[up_reg];
            rd_b_reg <= stack_mem[lo_reg];
        end
    end

    // goal memory: indexed by pancake magnitude
    always_ff @(posedge clk)
    begin
        if (ld_goal)
        begin
            goal_mem[IDX_W'(mag_in - 6'd1)] <= goal_val;
        end
        goal_rd_reg <= goal_mem[goal_addr];
    end

    // flip pointers and eval index
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            up_reg <= '0;
            lo_reg <= IDX_W'(flip_count - 5'd1);
        end
        else if (cmd.step)
        begin
            up_reg <= up_reg + 1'b1;
            lo_reg <= lo_reg - 1'b1;
        end
        else if (cmd.issue)
        begin
            up_reg <= up_reg + 1'b1;
        end
    end

    // gap terms of the entry leaving the pipeline
    assign loc      = s2_neg_reg ? -goal_rd_reg : goal_rd_reg;
    assign mag_a    = prev_loc_reg[PC_W-1] ? (~prev_loc_reg + 6'd1) : prev_loc_reg;
    assign mag_b    = loc[PC_W-1] ? (~loc + 6'd1) : loc;
    assign mag_diff = (mag_a > mag_b) ? (mag_a - mag_b) : (mag_b - mag_a);
    assign opp_sign = ((prev_loc_reg < 0) && (loc > 0)) || ((prev_loc_reg > 0) && (loc < 0));

    always_comb
    begin
        if (s2_first_reg)
        begin
            pair_inc = 2'd0;
        end
        else if (mag_diff > 6'd1)
        begin
            pair_inc = 2'd1;
        end
        else if (opp_sign)
        begin
            pair_inc = 2'd2;
        end
        else
        begin
            pair_inc = 2'd0;
        end
    end

    assign bot_inc = s2_last_reg && ({loc[PC_W-1], loc} != 7'(STACK_SIZE));

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // pipeline payload and gap accumulator
    always_ff @(posedge clk)
    begin
        s1_first_reg <= (up_reg == '0);
        s1_last_reg  <= status.idx_last;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_neg_reg   <= rd_a_reg[PC_W-1];
        if (cmd.accept)
        begin
            cnt_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            cnt_reg      <= cnt_reg + CNT_W'(pair_inc) + CNT_W'(bot_inc);
            prev_loc_reg <= loc;
        end
    end

    // saturate the count to the result width
    assign cnt_ext  = 8'(cnt_reg);
    assign heur_sat = (cnt_ext > 8'd31) ? 5'd31 : cnt_ext[HEUR_W-1:0];

    // loads and rejected flips answer right away
    assign immediate = (mode == MODE_LOAD_GOAL) || (mode == MODE_LOAD_CUR) ||
                       ((mode == MODE_FLIP) && !status.flip_ok);

    // result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.accept && immediate) || cmd.finish_flip || cmd.finish_eval;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            heur_reg <= '0;
            err_reg  <= (mode == MODE_FLIP) ? !status.flip_ok : load_bad;
        end
        else if (cmd.finish_flip)
        begin
            heur_reg <= '0;
            err_reg  <= 1'b0;
        end
        else if (cmd.finish_eval)
        begin
            heur_reg <= heur_sat;
            err_reg  <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign heuristic = heur_reg;
    assign error     = err_reg;

endmodule

FILE: rtl/signed_prefix_flip_gap_heuristic.sv
// ----------------------------------------------------------------------------
// signed_prefix_flip_gap_heuristic: burned pancake stack with gap count
// load goal and stack entries, flip signed prefixes, evaluate the gap count
// ----------------------------------------------------------------------------
// loads and rejected commands: result beat in the cycle after accept, next accept the same cycle
// flip of k: per pair a read, a write at up and a write at lo, then a final read (odd k adds a
// middle sign write), set by the single stack write port; evaluate: ST_EVAL walks every slot, then
// ST_DRAIN1, ST_DRAIN2 and ST_EDONE precede the beat; one stack read per cycle feeds a two stage goal lookup pipeline
// reset clears the controller and result strobe; memories stay undefined until loaded
// the result beat cannot be stalled: done is high for exactly one cycle per item
module signed_prefix_flip_gap_heuristic
    import spfgh_pkg::*;
#(
    parameter int STACK_SIZE = STACK_SIZE_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [MODE_W-1:0]       mode,
    input  logic [POS_W-1:0]        position,
    input  logic signed [PC_W-1:0]  pancake,
    input  logic [FLIP_W-1:0]       flip_count,
    output logic                    done,
    output logic [HEUR_W-1:0]       heuristic,
    output logic                    error
);

    localparam int EVAL_LAT = STACK_SIZE + 4;

    spfgh_cmd_t    cmd;
    spfgh_status_t status;

    // sequencing
    spfgh_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // storage and arithmetic
    spfgh_dp #(
        .STACK_SIZE (STACK_SIZE)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode),
        .position   (position),
        .pancake    (pancake),
        .flip_count (flip_count),
        .cmd        (cmd),
        .status     (status),
        .done       (done),
        .heuristic  (heuristic),
        .error      (error)
    );

    // evaluate beat arrives after the full walk and drain
    a_eval_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_EVAL) |-> ##EVAL_LAT done)
        else $error("evaluate result not on time");

    // loads answer on the next cycle with zero count
    a_load_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_LOAD_GOAL || mode == MODE_LOAD_CUR))
        |=> (done && heuristic == '0 && !busy))
        else $error("load result missing");

    // rejected flip reports error at once
    a_flip_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_FLIP && flip_count < 5'd2) |=> (done && error))
        else $error("bad flip count not rejected");

    // two entry flip takes one swap and one final check
    a_flip_two: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_FLIP && flip_count == 5'd2)
        |-> ##5 (done && !error))
        else $error("two entry flip result not on time");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: signed prefix flip gap heuristic
// drives goal and stack loads, signed prefix flips and evaluations through the
// start/busy command port, predicts every result beat in a small tracker class
// and compares heuristic and error field by field as each beat is strobed out
// ----------------------------------------------------------------------------
module testbench;
    import spfgh_pkg::*;

    localparam int N               = STACK_SIZE_DEF;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 600;
    localparam int DRAIN_CYCLES    = N + 8;

    // tracks goal table and stack, predicts one beat per accepted command
    class pancake_gap_tracker;
        typedef struct {
            logic [HEUR_W-1:0] heuristic;
            logic              error;
        } gap_beat_t;

        int        goal_slot[N];      // signed goal slot + 1 per pancake id
        int        stack_entry[N];    // signed pancake per slot, 0 is top
        gap_beat_t awaited[$];
        int        failures;
        int        mode_count[4];
        int        rejected;
        int        gap_min;
        int        gap_max;
        int        solved;

        function new();
            failures = 0;
            rejected = 0;
            gap_min  = 31;
            gap_max  = 0;
            solved   = 0;
            foreach (mode_count[i]) mode_count[i] = 0;
        endfunction

        // signed goal slot of the pancake sitting in stack slot i
        function int mapped_slot(int i);
            int p;
            int m;
            p = stack_entry[i];
            m = p < 0 ? -p : p;
            if (m < 1 || m > N)
                return 0;
            return p < 0 ? -goal_slot[m-1] : goal_slot[m-1];
        endfunction

        function int gap_count();
            int cnt;
            int a;
            int b;
            int d;
            cnt = 0;
            for (int i = 0; i < N - 1; i++)
            begin
                a = mapped_slot(i);
                b = mapped_slot(i + 1);
                d = (a < 0 ? -a : a) - (b < 0 ? -b : b);
                if (d < 0)
                    d = -d;
                if (d > 1)
                    cnt += 1;
                else if ((a < 0 && b > 0) || (a > 0 && b < 0))
                    cnt += 2;
            end
            if (mapped_slot(N - 1) != N)
                cnt += 1;
            return cnt > 31 ? 31 : cnt;
        endfunction

        function void apply_command(logic [MODE_W-1:0] md, logic [POS_W-1:0] pos,
                                    logic signed [PC_W-1:0] pc, logic [FLIP_W-1:0] k);
            gap_beat_t beat;
            int        p;
            int        m;
            int        slot;
            int        kk;
            int        flipped[N];
            int        cnt;
            beat.heuristic = '0;
            beat.error     = 1'b0;
            p    = int'(pc);
            m    = p < 0 ? -p : p;
            slot = int'(pos);
            kk   = int'(k);
            mode_count[md]++;
            case (md)
                MODE_LOAD_GOAL, MODE_LOAD_CUR:
                begin
                    if (p == 0 || m > N)
                        beat.error = 1'b1;
                    else if (slot < N)
                    begin
                        if (md == MODE_LOAD_GOAL)
                            goal_slot[m-1] = p < 0 ? -(slot + 1) : slot + 1;
                        else
                            stack_entry[slot] = p;
                    end
                end
                MODE_FLIP:
                begin
                    if (kk < 2 || kk > N)
                        beat.error = 1'b1;
                    else
                    begin
                        for (int i = 0; i < kk; i++)
                            flipped[i] = -stack_entry[kk-1-i];
                        for (int i = 0; i < kk; i++)
                            stack_entry[i] = flipped[i];
                    end
                end
                MODE_EVAL:
                begin
                    cnt = gap_count();
                    beat.heuristic = cnt[HEUR_W-1:0];
                    if (cnt < gap_min) gap_min = cnt;
                    if (cnt > gap_max) gap_max = cnt;
                    if (cnt == 0) solved++;
                end
            endcase
            if (beat.error)
                rejected++;
            awaited.insert(awaited.size(), beat);
        endfunction

        function void check_beat(logic [HEUR_W-1:0] h, logic e);
            gap_beat_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected result beat: heuristic %0d error %0d", h, e);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (h !== want.heuristic)
            begin
                $error("heuristic mismatch: expected %0d, actual %0d", want.heuristic, h);
                failures++;
            end
            if (e !== want.error)
            begin
                $error("error mismatch: expected %0d, actual %0d", want.error, e);
                failures++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n      = 1'b0;
    logic                   start      = 1'b0;
    logic                   busy;
    logic [MODE_W-1:0]      mode       = MODE_LOAD_GOAL;
    logic [POS_W-1:0]       position   = '0;
    logic signed [PC_W-1:0] pancake    = '0;
    logic [FLIP_W-1:0]      flip_count = '0;
    logic                   done;
    logic [HEUR_W-1:0]      heuristic;
    logic                   error;

    pancake_gap_tracker tracker;
    int cycle_count     = 0;
    int items_sent      = 0;
    int sender_idle_pct = 0;
    int goal_layout[N];
    int stack_layout[N];
    int perm_buf[N];

    signed_prefix_flip_gap_heuristic i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .position   (position),
        .pancake    (pancake),
        .flip_count (flip_count),
        .done       (done),
        .heuristic  (heuristic),
        .error      (error)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("signed_prefix_flip_gap_heuristic test failed");
            $finish;
        end
    end

    // result beats cannot be held off, check each strobed beat
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_beat(heuristic, error);
    end

    // one command beat, with random sender gaps ahead of it
    task automatic push_command(logic [MODE_W-1:0] md, int pos, int pc, int k);
        logic [POS_W-1:0]       pos_bits;
        logic signed [PC_W-1:0] pc_bits;
        logic [FLIP_W-1:0]      k_bits;
        pos_bits = pos[POS_W-1:0];
        pc_bits  = pc[PC_W-1:0];
        k_bits   = k[FLIP_W-1:0];
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= md;
        position   <= pos_bits;
        pancake    <= pc_bits;
        flip_count <= k_bits;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.apply_command(md, pos_bits, pc_bits, k_bits);
        items_sent++;
    endtask

    task automatic flip_prefix(int k);
        push_command(MODE_FLIP, $urandom_range(0, 15), $urandom_range(0, 63), k);
    endtask

    task automatic evaluate_stack();
        push_command(MODE_EVAL, $urandom_range(0, 15), $urandom_range(0, 63),
                     $urandom_range(0, 31));
    endtask

    // fully random beat, any field value
    task automatic noise_item();
        push_command(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 15),
                     $urandom_range(0, 63), $urandom_range(0, 31));
    endtask

    // write a whole goal or stack layout, top-down or bottom-up
    task automatic load_layout(logic [MODE_W-1:0] md);
        int s;
        bit upward;
        upward = 1'($urandom_range(0, 1));
        for (int i = 0; i < N; i++)
        begin
            s = upward ? i : N - 1 - i;
            push_command(md, s, md == MODE_LOAD_GOAL ? goal_layout[s] : stack_layout[s],
                         $urandom_range(0, 31));
        end
    endtask

    task automatic draw_signed_perm();
        int j;
        int t;
        for (int i = 0; i < N; i++)
            perm_buf[i] = i + 1;
        for (int i = N - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = perm_buf[i];
            perm_buf[i] = perm_buf[j];
            perm_buf[j] = t;
        end
        for (int i = 0; i < N; i++)
            if ($urandom_range(0, 1))
                perm_buf[i] = -perm_buf[i];
    endtask

    // stop sending until every outstanding beat has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        // rejected flip counts, safe before anything is loaded
        flip_prefix(0);
        flip_prefix(1);
        flip_prefix(N + 1);
        flip_prefix(31);
        // zero and out-of-range pancakes are rejected
        push_command(MODE_LOAD_GOAL, 0, 0, 0);
        push_command(MODE_LOAD_GOAL, 15, N + 1, 0);
        push_command(MODE_LOAD_CUR, 3, -(N + 1), 0);
        push_command(MODE_LOAD_CUR, 15, -32, 0);
        push_command(MODE_LOAD_CUR, 0, 31, 0);
        // identity goal, then alternating signs for the heaviest count
        for (int s = 0; s < N; s++)
        begin
            goal_layout[s]  = s + 1;
            stack_layout[s] = (s % 2) ? -(s + 1) : s + 1;
        end
        load_layout(MODE_LOAD_GOAL);
        load_layout(MODE_LOAD_CUR);
        evaluate_stack();
        // solved stack, full flips there and back
        stack_layout = goal_layout;
        load_layout(MODE_LOAD_CUR);
        evaluate_stack();
        flip_prefix(N);
        evaluate_stack();
        flip_prefix(N);
        evaluate_stack();
        // smallest flip and an odd one with a negated middle
        flip_prefix(2);
        flip_prefix(N - 1);
        evaluate_stack();
        // magnitude and slot extremes
        push_command(MODE_LOAD_CUR, 0, -N, 0);
        push_command(MODE_LOAD_CUR, N - 1, N, 0);
        push_command(MODE_LOAD_GOAL, N - 1, -N, 0);
        evaluate_stack();
    endtask

    // goal and stack set up, then a run of flips with evaluations
    task automatic run_scenario();
        int j;
        int r;
        int k;
        if ($urandom_range(0, 99) < 60)
        begin
            draw_signed_perm();
            goal_layout = perm_buf;
            load_layout(MODE_LOAD_GOAL);
        end
        case ($urandom_range(0, 3))
            0: stack_layout = goal_layout;
            1:
            begin
                stack_layout = goal_layout;
                j = $urandom_range(0, N - 1);
                stack_layout[j] = -stack_layout[j];
            end
            2:
            begin
                draw_signed_perm();
                stack_layout = perm_buf;
            end
            default:
            begin
                for (int s = 0; s < N; s++)
                    stack_layout[s] = $urandom_range(0, 1) ? -$urandom_range(1, N)
                                                           : $urandom_range(1, N);
            end
        endcase
        load_layout(MODE_LOAD_CUR);
        evaluate_stack();
        repeat ($urandom_range(1, 10))
        begin
            r = $urandom_range(0, 9);
            k = (r == 0) ? 2 : (r == 1) ? N : $urandom_range(2, N);
            flip_prefix(k);
            if ($urandom_range(0, 1))
                evaluate_stack();
            if ($urandom_range(0, 99) < 4)
                noise_item();
        end
        evaluate_stack();
    endtask

    task automatic run_phase();
        int base;
        int pause_at;
        bit paused;
        base     = items_sent;
        pause_at = $urandom_range(50, ITEMS_PER_PHASE - 100);
        paused   = 1'b0;
        while (items_sent - base < ITEMS_PER_PHASE)
        begin
            if (!paused && items_sent - base >= pause_at)
            begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 80)
                run_scenario();
            else
                repeat ($urandom_range(1, 6)) noise_item();
        end
    endtask

    // main sequence
    initial
    begin
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        sender_idle_pct = 8;
        run_phase();
        sender_idle_pct = 73;
        run_phase();
        sender_idle_pct = 0;
        run_phase();
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d commands: %0d goal loads, %0d stack loads, %0d flips, %0d evals",
                 items_sent, tracker.mode_count[MODE_LOAD_GOAL],
                 tracker.mode_count[MODE_LOAD_CUR], tracker.mode_count[MODE_FLIP],
                 tracker.mode_count[MODE_EVAL]);
        $display("%0d rejected commands, gap counts %0d..%0d, %0d solved stacks seen",
                 tracker.rejected, tracker.gap_min, tracker.gap_max, tracker.solved);
        if (tracker.failures == 0)
            $display("signed_prefix_flip_gap_heuristic test passed");
        else
            $display("signed_prefix_flip_gap_heuristic test failed");
        $finish;
    end

endmodule
